/* rtl/itoa_pkg.sv */
// itoa_pkg: shared types and constants of the integer to ascii formatter
// used by the interfaces, controller, datapath and top level; no dependencies
`timescale 1ns / 1ps

package itoa_pkg;

	localparam int VALUE_W = 32;
	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 7;
	localparam int DIGITS  = 10;
	localparam int BCD_W   = 4 * DIGITS;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SDEC = 2'd0,
		FUNC_UDEC = 2'd1,
		FUNC_LHEX = 2'd2,
		FUNC_UHEX = 2'd3
	} func_t;

	// what the datapath puts in the output register on an emit
	typedef enum logic [1:0] {
		EMIT_SIGN  = 2'd0,
		EMIT_ZERO  = 2'd1,
		EMIT_X     = 2'd2,
		EMIT_DIGIT = 2'd3
	} emit_sel_t;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_UP_A  = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;

	typedef struct packed {
		logic      load;
		logic      conv_step;
		logic      skip_step;
		logic      emit;
		emit_sel_t emit_sel;
	} itoa_cmd_t;

	typedef struct packed {
		logic is_hex;
		logic is_neg;
		logic conv_done;
		logic top_zero;
		logic one_left;
	} itoa_sts_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CHAR_UP_A : CHAR_LOW_A;
		if (nib < 4'd10)
			return CHAR_ZERO + {3'd0, nib};
		else
			return base + {3'd0, nib - 4'd10};
	endfunction

endpackage

/* rtl/itoa_if.sv */
// itoa_in_if, itoa_out_if: valid/ready channels of the formatter
// depends on itoa_pkg for field widths
`timescale 1ns / 1ps

interface itoa_in_if;
	logic                               valid;
	logic                               ready;
	logic [itoa_pkg::VALUE_W-1:0]       value;
	logic [itoa_pkg::FUNC_W-1:0]        func;

	modport source (output valid, output value, output func, input ready);
	modport sink   (input valid, input value, input func, output ready);
endinterface

interface itoa_out_if;
	logic                               valid;
	logic                               ready;
	logic [itoa_pkg::CHAR_W-1:0]        character;
	logic                               last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/itoa_dp.sv */
// itoa_dp: datapath with double-dabble converter, digit shifter and output register
// depends on itoa_pkg; driven by itoa_ctrl through itoa_cmd_t
`timescale 1ns / 1ps

module itoa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [itoa_pkg::VALUE_W-1:0]  value,
	input  logic [itoa_pkg::FUNC_W-1:0]   func,
	input  itoa_pkg::itoa_cmd_t           cmd,
	output itoa_pkg::itoa_sts_t           sts,
	output logic [itoa_pkg::CHAR_W-1:0]   character,
	output logic                          last
);

	logic [itoa_pkg::VALUE_W-1:0] bin_q;
	logic [itoa_pkg::BCD_W-1:0]   bcd_q;
	logic [4:0]                   cnt_q;
	logic [3:0]                   rem_q;
	logic                         hex_q;
	logic                         upper_q;
	logic                         neg_q;
	logic [itoa_pkg::CHAR_W-1:0]  char_q;
	logic                         last_q;

	logic [itoa_pkg::BCD_W-1:0]   bcd_adj;
	logic                         neg_in;
	logic [itoa_pkg::CHAR_W-1:0]  digit_char;

	assign neg_in = (func == itoa_pkg::FUNC_SDEC) && value[itoa_pkg::VALUE_W-1];

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < itoa_pkg::DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		if (hex_q)
			digit_char = itoa_pkg::hex_char(bin_q[itoa_pkg::VALUE_W-1 -: 4], upper_q);
		else
			digit_char = itoa_pkg::CHAR_ZERO + {3'd0, bcd_q[itoa_pkg::BCD_W-1 -: 4]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
			hex_q <= 1'b0;
			neg_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			hex_q <= func[1];
			neg_q <= neg_in;
			rem_q <= func[1] ? 4'd8 : 4'(itoa_pkg::DIGITS);
		end else begin
			if (cmd.conv_step)
				cnt_q <= cnt_q + 5'd1;
			if (cmd.skip_step || (cmd.emit && cmd.emit_sel == itoa_pkg::EMIT_DIGIT))
				rem_q <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q   <= neg_in ? (~value + 32'd1) : value;
			bcd_q   <= '0;
			upper_q <= (func == itoa_pkg::FUNC_UHEX);
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[itoa_pkg::BCD_W-2:0], bin_q[itoa_pkg::VALUE_W-1]};
			bin_q <= {bin_q[itoa_pkg::VALUE_W-2:0], 1'b0};
		end else if (cmd.skip_step) begin
			bcd_q <= {bcd_q[itoa_pkg::BCD_W-5:0], 4'd0};
		end else if (cmd.emit && cmd.emit_sel == itoa_pkg::EMIT_DIGIT) begin
			if (hex_q)
				bin_q <= {bin_q[itoa_pkg::VALUE_W-5:0], 4'd0};
			else
				bcd_q <= {bcd_q[itoa_pkg::BCD_W-5:0], 4'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_sel)
				itoa_pkg::EMIT_SIGN: begin
					char_q <= itoa_pkg::CHAR_MINUS;
					last_q <= 1'b0;
				end
				itoa_pkg::EMIT_ZERO: begin
					char_q <= itoa_pkg::CHAR_ZERO;
					last_q <= 1'b0;
				end
				itoa_pkg::EMIT_X: begin
					char_q <= itoa_pkg::CHAR_X;
					last_q <= 1'b0;
				end
				itoa_pkg::EMIT_DIGIT: begin
					char_q <= digit_char;
					last_q <= (rem_q == 4'd1);
				end
				default: begin
					char_q <= digit_char;
					last_q <= 1'b0;
				end
			endcase
		end
	end

	assign sts.is_hex    = hex_q;
	assign sts.is_neg    = neg_q;
	assign sts.conv_done = (cnt_q == 5'd31);
	assign sts.top_zero  = (bcd_q[itoa_pkg::BCD_W-1 -: 4] == 4'd0);
	assign sts.one_left  = (rem_q == 4'd1);

	assign character = char_q;
	assign last      = last_q;

endmodule

/* rtl/itoa_ctrl.sv */
// itoa_ctrl: sequencing state machine and output valid flag of the formatter
// depends on itoa_pkg; commands itoa_dp
`timescale 1ns / 1ps

module itoa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  itoa_pkg::itoa_sts_t sts,
	output itoa_pkg::itoa_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CONV  = 7'b0000010,
		ST_SKIP  = 7'b0000100,
		ST_SIGN  = 7'b0001000,
		ST_PFX0  = 7'b0010000,
		ST_PFX1  = 7'b0100000,
		ST_DIGIT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_nxt     = state_q;
		cmd.load      = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.skip_step = 1'b0;
		cmd.emit      = 1'b0;
		cmd.emit_sel  = itoa_pkg::EMIT_DIGIT;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				if (sts.is_hex) begin
					state_nxt = ST_PFX0;
				end else begin
					cmd.conv_step = 1'b1;
					if (sts.conv_done)
						state_nxt = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zero digits, always keep the last one
				if (sts.top_zero && !sts.one_left)
					cmd.skip_step = 1'b1;
				else if (sts.is_neg)
					state_nxt = ST_SIGN;
				else
					state_nxt = ST_DIGIT;
			end
			ST_SIGN: begin
				cmd.emit_sel = itoa_pkg::EMIT_SIGN;
				if (slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_DIGIT;
				end
			end
			ST_PFX0: begin
				cmd.emit_sel = itoa_pkg::EMIT_ZERO;
				if (slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_PFX1;
				end
			end
			ST_PFX1: begin
				cmd.emit_sel = itoa_pkg::EMIT_X;
				if (slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (sts.one_left)
						state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("character loaded over an untaken beat");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	a_skip_keeps_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.skip_step |-> (state_q == ST_SKIP && !sts.one_left && !sts.is_hex))
		else $error("skip would drop the last digit");

	a_conv_to_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && cmd.conv_step && sts.conv_done) |=> state_q == ST_SKIP)
		else $error("conversion end missed");

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// Each accepted number is loaded and then, for the two decimal formats, goes through 32
// double-dabble shifts, one skip step per leading zero digit dropped (0 to 9), a step to
// settle on the first kept digit and one character per cycle while the output is not
// stalled; dropped and printed digits always add up to ten, and a minus sign adds one
// character. The hex formats pass through one idle state and then give ten characters;
// the decimal ones use the shift-and-add-three converter. A stalled output holds the
// emitting states. A new number is taken only once the last character of
// the previous one is in the output register, which may still be waiting to be taken.
`timescale 1ns / 1ps

module integer_to_ascii_formatter (
	input  logic       clk,
	input  logic       arst_n,
	itoa_in_if.sink    in_ch,
	itoa_out_if.source out_ch
);

	itoa_pkg::itoa_cmd_t cmd;
	itoa_pkg::itoa_sts_t sts;

	itoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	itoa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (in_ch.value),
		.func      (in_ch.func),
		.cmd       (cmd),
		.sts       (sts),
		.character (out_ch.character),
		.last      (out_ch.last)
	);

endmodule

/* test/tb_integer_to_ascii_formatter.sv */
// tb_integer_to_ascii_formatter: self-checking bench that predicts every ascii beat
// depends on itoa_pkg, itoa_in_if / itoa_out_if and integer_to_ascii_formatter
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 60;
	localparam int MAX_REPORTS = 20;

	typedef struct {
		logic [itoa_pkg::CHAR_W-1:0] character;
		logic                        last;
	} ascii_beat_t;

	class char_run_board;
		ascii_beat_t pending_chars[$];
		int          numbers_seen;
		int          chars_checked;
		int          errors;

		// expand one accepted number into the characters it must produce
		function void note_number(logic [itoa_pkg::VALUE_W-1:0] num, itoa_pkg::func_t fmt);
			ascii_beat_t                  run[$];
			ascii_beat_t                  beat;
			logic [itoa_pkg::VALUE_W-1:0] mag;
			logic [3:0]                   nib;
			logic [3:0]                   digs[itoa_pkg::DIGITS];
			int                           nd;
			beat.last = 1'b0;
			numbers_seen++;
			if (fmt == itoa_pkg::FUNC_LHEX || fmt == itoa_pkg::FUNC_UHEX) begin
				beat.character = itoa_pkg::CHAR_ZERO;
				run.push_back(beat);
				beat.character = itoa_pkg::CHAR_X;
				run.push_back(beat);
				for (int i = 7; i >= 0; i--) begin
					nib = num[4*i +: 4];
					if (nib < 4'd10)
						beat.character = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(nib);
					else if (fmt == itoa_pkg::FUNC_UHEX)
						beat.character = itoa_pkg::CHAR_UP_A
							+ itoa_pkg::CHAR_W'(nib - 4'd10);
					else
						beat.character = itoa_pkg::CHAR_LOW_A
							+ itoa_pkg::CHAR_W'(nib - 4'd10);
					run.push_back(beat);
				end
			end else begin
				mag = num;
				if (fmt == itoa_pkg::FUNC_SDEC && num[itoa_pkg::VALUE_W-1]) begin
					beat.character = itoa_pkg::CHAR_MINUS;
					run.push_back(beat);
					mag = -num;
				end
				nd = 0;
				do begin
					digs[nd] = 4'(mag % 10);
					mag = mag / 10;
					nd++;
				end while (mag != 0 && nd < itoa_pkg::DIGITS);
				while (nd > 0) begin
					nd--;
					beat.character = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(digs[nd]);
					run.push_back(beat);
				end
			end
			run[run.size()-1].last = 1'b1;
			foreach (run[i])
				pending_chars.push_back(run[i]);
		endfunction

		function void check_char(logic [itoa_pkg::CHAR_W-1:0] got_char, logic got_last);
			ascii_beat_t want;
			chars_checked++;
			if (pending_chars.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected beat, got char %h last %b",
						$time, got_char, got_last);
				return;
			end
			want = pending_chars.pop_front();
			if (got_char !== want.character) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: character mismatch, expected %h got %h",
						$time, want.character, got_char);
			end
			if (got_last !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: last mismatch, expected %b got %b",
						$time, want.last, got_last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on = 1'b0;
	int   quiet_cycles = 0;

	char_run_board board = new();

	itoa_in_if  in_bus ();
	itoa_out_if out_bus ();

	integer_to_ascii_formatter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	always #5 clk = ~clk;

	// both channels sampled at the edge, before any nonblocking update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready)
				board.note_number(in_bus.value, itoa_pkg::func_t'(in_bus.func));
			if (out_bus.valid && out_bus.ready)
				board.check_char(out_bus.character, out_bus.last);
		end
	end

	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// output back-pressure in random bursts while idling is on
	initial begin
		out_bus.ready <= 1'b0;
		@(posedge clk);
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				out_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic send_number(logic [itoa_pkg::VALUE_W-1:0] num, itoa_pkg::func_t fmt);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.value <= num;
		in_bus.func  <= fmt;
		do
			@(posedge clk);
		while (!in_bus.ready);
	endtask

	// hold the input off until every predicted character has come out
	task automatic drain_chars();
		in_bus.valid <= 1'b0;
		while (board.pending_chars.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [itoa_pkg::VALUE_W-1:0] pick_value();
		logic [itoa_pkg::VALUE_W-1:0] p;
		p = 1;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(0, 31);
			2: return -($urandom >> $urandom_range(0, 31));
			default: begin
				// straddle a power of ten to hit every digit count
				repeat ($urandom_range(0, 9)) p = p * 10;
				return p - 1 + $urandom_range(0, 2);
			end
		endcase
	endfunction

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_number(pick_value(), itoa_pkg::func_t'($urandom_range(0, 3)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_bus.valid <= 1'b0;
		in_bus.value <= '0;
		in_bus.func  <= itoa_pkg::FUNC_SDEC;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner values of every format, back to back
		send_number(32'h0000_0000, itoa_pkg::FUNC_SDEC);
		send_number(32'h8000_0000, itoa_pkg::FUNC_SDEC);
		send_number(32'h7FFF_FFFF, itoa_pkg::FUNC_SDEC);
		send_number(32'hFFFF_FFFF, itoa_pkg::FUNC_SDEC);
		send_number(32'hFFFF_FFF6, itoa_pkg::FUNC_SDEC);
		send_number(32'd9, itoa_pkg::FUNC_SDEC);
		send_number(32'd10, itoa_pkg::FUNC_SDEC);
		send_number(32'h0000_0000, itoa_pkg::FUNC_UDEC);
		send_number(32'hFFFF_FFFF, itoa_pkg::FUNC_UDEC);
		send_number(32'h8000_0000, itoa_pkg::FUNC_UDEC);
		send_number(32'd999999999, itoa_pkg::FUNC_UDEC);
		send_number(32'd1000000000, itoa_pkg::FUNC_UDEC);
		send_number(32'd1, itoa_pkg::FUNC_UDEC);
		send_number(32'h0000_0000, itoa_pkg::FUNC_LHEX);
		send_number(32'hFFFF_FFFF, itoa_pkg::FUNC_LHEX);
		send_number(32'h0123_ABCD, itoa_pkg::FUNC_LHEX);
		send_number(32'h89AB_CDEF, itoa_pkg::FUNC_LHEX);
		send_number(32'h0000_0000, itoa_pkg::FUNC_UHEX);
		send_number(32'hFFFF_FFFF, itoa_pkg::FUNC_UHEX);
		send_number(32'h0123_ABCD, itoa_pkg::FUNC_UHEX);
		send_number(32'h89AB_CDEF, itoa_pkg::FUNC_UHEX);
		drain_chars();

		idle_on = 1'b1;
		send_random(300);
		drain_chars();
		send_random(80);

		// closing stretch at full rate
		idle_on = 1'b0;
		send_random(100);
		drain_chars();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d numbers across signed, unsigned, lower and upper hex",
			board.numbers_seen);
		$display("checked %0d characters under random stalls on both channels",
			board.chars_checked);
		if (board.errors == 0 && board.pending_chars.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d characters never seen",
				board.errors, board.pending_chars.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/itoa_pkg.sv
rtl/itoa_if.sv
rtl/itoa_dp.sv
rtl/itoa_ctrl.sv
rtl/integer_to_ascii_formatter.sv
test/tb_integer_to_ascii_formatter.sv
